// File: src/nrp_pkg.sv
// Package for the NMEA RMC position parser: constants, types, helpers.
// No dependencies.
package nrp_pkg;

    localparam int MINUTE_FRAC_DIGITS_DEF = 5;
    localparam int MAX_FIELDS_DEF         = 16;
    localparam int INT_PART_MAX           = 131071;
    localparam int QUEUE_DEPTH            = 2;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;

    localparam logic [2:0] ST_NOT_RMC   = 3'd0;
    localparam logic [2:0] ST_FEW       = 3'd1;
    localparam logic [2:0] ST_VALID     = 3'd2;
    localparam logic [2:0] ST_NO_FIX    = 3'd3;
    localparam logic [2:0] ST_EMPTY_POS = 3'd4;

    // One parsed coordinate field, as it stands at end of line
    // (fraction wide enough for up to seven kept minute digits)
    typedef struct packed {
        logic [16:0] int_part;
        logic [23:0] frac_part;
        logic [2:0]  frac_cnt;
        logic        neg;
    } coord_t;

    // Classified line handed from front to back
    typedef struct packed {
        logic [2:0] status;
        coord_t     lat;
        coord_t     lon;
    } line_t;

    // Expected prefix character at a position, for "$GPRMC" / "$GNRMC"
    function automatic logic [7:0] pfx_char(input logic [2:0] pos, input logic gn);
        logic [7:0] c;
        begin
            case (pos)
                3'd0: c = 8'h24;
                3'd1: c = 8'h47;
                3'd2: c = gn ? 8'h4e : 8'h50;
                3'd3: c = 8'h52;
                3'd4: c = 8'h4d;
                3'd5: c = 8'h43;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // Power of ten for small exponents
    function automatic logic [23:0] pow10(input logic [2:0] e);
        logic [23:0] p;
        begin
            case (e)
                3'd0: p = 24'd1;
                3'd1: p = 24'd10;
                3'd2: p = 24'd100;
                3'd3: p = 24'd1000;
                3'd4: p = 24'd10000;
                3'd5: p = 24'd100000;
                3'd6: p = 24'd1000000;
                default: p = 24'd10000000;
            endcase
            return p;
        end
    endfunction

endpackage

// File: src/nrp_front.sv
// Front end: per-byte line scanner, classifies a finished line.
// Depends on nrp_pkg.
module nrp_front #(
    parameter int MINUTE_FRAC_DIGITS = nrp_pkg::MINUTE_FRAC_DIGITS_DEF,
    parameter int MAX_FIELDS         = nrp_pkg::MAX_FIELDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    input  logic [7:0]       byte_data,
    output logic             line_valid,
    output nrp_pkg::line_t   line_data
);
    import nrp_pkg::*;

    localparam int FW = $clog2(MAX_FIELDS);

    logic          nonempty_reg, nonempty_next;
    logic [2:0]    ppos_reg, ppos_next;
    logic [1:0]    pok_reg, pok_next;
    logic [FW-1:0] fnum_reg, fnum_next;
    logic [1:0]    scnt_reg, scnt_next;
    logic          isa_reg, isa_next;
    logic [16:0]   ip_reg [2], ip_next [2];
    logic [23:0]   fp_reg [2], fp_next [2];
    logic [2:0]    cnt_reg [2], cnt_next [2];
    logic [1:0]    ne_reg, ne_next, dot_reg, dot_next, end_reg, end_next;
    logic [1:0]    hemi_reg, hemi_next, neg_reg, neg_next;
    logic          end_line;
    logic [3:0]    digit;
    logic          is_digit;
    logic [26:0]   acc;

    assign is_digit = (byte_data >= 8'h30) && (byte_data <= 8'h39);
    assign digit    = byte_data[3:0];
    assign end_line = byte_valid && (byte_data == CH_LF) && nonempty_reg;

    // Next-state for the scanner
    always_comb
    begin
        nonempty_next = nonempty_reg;
        ppos_next = ppos_reg;
        pok_next  = pok_reg;
        fnum_next = fnum_reg;
        scnt_next = scnt_reg;
        isa_next  = isa_reg;
        ip_next   = ip_reg;
        fp_next   = fp_reg;
        cnt_next  = cnt_reg;
        ne_next   = ne_reg;
        dot_next  = dot_reg;
        end_next  = end_reg;
        hemi_next = hemi_reg;
        neg_next  = neg_reg;
        acc       = '0;
        if (byte_valid && byte_data != CH_CR) begin
            if (byte_data == CH_LF) begin
                nonempty_next = 1'b0;
                ppos_next = '0;
                pok_next  = 2'b11;
                fnum_next = '0;
                scnt_next = '0;
                isa_next  = 1'b0;
                for (int k = 0; k < 2; k++) begin
                    ip_next[k]  = '0;
                    fp_next[k]  = '0;
                    cnt_next[k] = '0;
                end
                ne_next = '0; dot_next = '0; end_next = '0;
                hemi_next = '0; neg_next = '0;
            end else begin
                nonempty_next = 1'b1;
                if (ppos_reg < 3'd6) begin
                    if (byte_data != pfx_char(ppos_reg, 1'b0)) pok_next[0] = 1'b0;
                    if (byte_data != pfx_char(ppos_reg, 1'b1)) pok_next[1] = 1'b0;
                    ppos_next = ppos_reg + 3'd1;
                end
                if (byte_data == CH_COMMA) begin
                    if (fnum_reg < FW'(MAX_FIELDS - 1))
                        fnum_next = fnum_reg + FW'(1);
                end else begin
                    for (int k = 0; k < 2; k++) begin
                        // number field: 3 for latitude, 5 for longitude
                        if (fnum_reg == FW'(3 + 2 * k)) begin
                            ne_next[k] = 1'b1;
                            if (!end_reg[k]) begin
                                if (is_digit) begin
                                    if (!dot_reg[k]) begin
                                        acc = {7'd0, ip_reg[k], 3'b0}
                                            + {9'd0, ip_reg[k], 1'b0}
                                            + {23'd0, digit};
                                        ip_next[k] = (acc > 27'(INT_PART_MAX)) ?
                                            17'(INT_PART_MAX) : acc[16:0];
                                    end else if (cnt_reg[k] < 3'(MINUTE_FRAC_DIGITS)) begin
                                        acc = {fp_reg[k], 3'b0} + {2'b0, fp_reg[k], 1'b0}
                                            + {23'd0, digit};
                                        fp_next[k]  = acc[23:0];
                                        cnt_next[k] = cnt_reg[k] + 3'd1;
                                    end
                                end else if (byte_data == CH_DOT && !dot_reg[k]) begin
                                    dot_next[k] = 1'b1;
                                end else begin
                                    end_next[k] = 1'b1;
                                end
                            end
                        end
                        // hemisphere field: first character only
                        if (fnum_reg == FW'(4 + 2 * k) && !hemi_reg[k]) begin
                            hemi_next[k] = 1'b1;
                            neg_next[k]  = (byte_data == CH_S) || (byte_data == CH_W);
                        end
                    end
                    if (fnum_reg == FW'(2)) begin
                        if (scnt_reg == 2'd0) isa_next = (byte_data == CH_A);
                        if (scnt_reg < 2'd2) scnt_next = scnt_reg + 2'd1;
                    end
                end
            end
        end
    end

    // Classify the finished line
    always_comb
    begin
        line_valid = end_line;
        if (ppos_reg < 3'd6 || pok_reg == 2'b00)
            line_data.status = ST_NOT_RMC;
        else if (fnum_reg < FW'(6))
            line_data.status = ST_FEW;
        else if (!(scnt_reg == 2'd1 && isa_reg))
            line_data.status = ST_NO_FIX;
        else if (ne_reg != 2'b11 || hemi_reg != 2'b11)
            line_data.status = ST_EMPTY_POS;
        else
            line_data.status = ST_VALID;
        line_data.lat = '{int_part: ip_reg[0], frac_part: fp_reg[0],
                          frac_cnt: cnt_reg[0], neg: neg_reg[0]};
        line_data.lon = '{int_part: ip_reg[1], frac_part: fp_reg[1],
                          frac_cnt: cnt_reg[1], neg: neg_reg[1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            nonempty_reg <= 1'b0;
            ppos_reg <= '0;
            pok_reg  <= 2'b11;
            fnum_reg <= '0;
            scnt_reg <= '0;
            isa_reg  <= 1'b0;
            for (int k = 0; k < 2; k++) begin
                ip_reg[k]  <= '0;
                fp_reg[k]  <= '0;
                cnt_reg[k] <= '0;
            end
            ne_reg <= '0; dot_reg <= '0; end_reg <= '0;
            hemi_reg <= '0; neg_reg <= '0;
        end else begin
            nonempty_reg <= nonempty_next;
            ppos_reg <= ppos_next;
            pok_reg  <= pok_next;
            fnum_reg <= fnum_next;
            scnt_reg <= scnt_next;
            isa_reg  <= isa_next;
            ip_reg   <= ip_next;
            fp_reg   <= fp_next;
            cnt_reg  <= cnt_next;
            ne_reg   <= ne_next;
            dot_reg  <= dot_next;
            end_reg  <= end_next;
            hemi_reg <= hemi_next;
            neg_reg  <= neg_next;
        end
    end

endmodule

// File: src/nrp_queue.sv
// Small FIFO of classified lines between front and back.
// Depends on nrp_pkg.
module nrp_queue #(
    parameter int DEPTH = nrp_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  nrp_pkg::line_t wr_data,
    output logic           full,
    output logic           rd_valid,
    input  logic           rd_en,
    output nrp_pkg::line_t rd_data
);
    import nrp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    line_t          mem_reg [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;

    assign full     = (cnt_reg == (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (rd_en)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule

// File: src/nrp_back.sv
// Back end: converts a classified line to degrees e7, updates the held
// fix and position, and drives the result register. Depends on nrp_pkg.
module nrp_back #(
    parameter int MINUTE_FRAC_DIGITS = nrp_pkg::MINUTE_FRAC_DIGITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_take,
    input  nrp_pkg::line_t  in_data,
    output logic            res_valid,
    input  logic            res_ready,
    output logic [2:0]      res_status,
    output logic            res_fix,
    output logic signed [34:0] res_lat,
    output logic signed [34:0] res_lon
);
    import nrp_pkg::*;

    // Minutes scale 10^d; minutes * 10^(7-d) / 60 gives the 1e-7 degree part
    localparam longint     SCALE   = 64'd10 ** MINUTE_FRAC_DIGITS;
    localparam longint     NUM_MUL = 64'd10 ** (7 - MINUTE_FRAC_DIGITS);
    localparam int         RSH     = 36;
    // ceil(2^36 / 60), exact for numerators below 2^30
    localparam logic [30:0] RECIP60 = 31'd1145324613;

    // Stage 1: split degrees/minutes, build minute value
    logic         s1_valid_reg;
    logic [2:0]   s1_status_reg;
    logic [10:0]  s1_deg_reg [2];
    logic [30:0]  s1_min_reg [2];
    logic [1:0]   s1_neg_reg;
    // Stage 2: minute value in 1e-7 minute units
    logic         s2_valid_reg;
    logic [2:0]   s2_status_reg;
    logic [10:0]  s2_deg_reg [2];
    logic [29:0]  s2_num_reg [2];
    logic [1:0]   s2_neg_reg;
    // Stage 3: quotient
    logic         s3_valid_reg;
    logic [2:0]   s3_status_reg;
    logic [10:0]  s3_deg_reg [2];
    logic [27:0]  s3_q_reg [2];
    logic [1:0]   s3_neg_reg;

    logic         held_fix_reg;
    logic [34:0]  held_lat_reg, held_lon_reg;
    logic         out_valid_reg;
    logic [2:0]   out_status_reg;

    logic         adv;
    logic [10:0]  deg_c [2];
    logic [6:0]   mm_c [2];
    logic [30:0]  min_c [2];
    logic [27:0]  q_c [2];
    logic [34:0]  mag_c [2];
    logic [34:0]  val_c [2];
    coord_t       cin [2];

    // Whole pipe moves when the result slot is free or being taken
    assign adv     = !out_valid_reg || res_ready;
    assign in_take = adv && in_valid;

    assign cin[0] = in_data.lat;
    assign cin[1] = in_data.lon;

    // Stage 1 combinational: ip / 100 via reciprocal, fraction scaling
    always_comb
    begin
        for (int k = 0; k < 2; k++) begin
            deg_c[k] = 11'((35'(cin[k].int_part) * 35'd167773) >> 24);
            mm_c[k]  = 7'(cin[k].int_part - 17'(deg_c[k]) * 17'd100);
            min_c[k] = 31'(64'(mm_c[k]) * SCALE)
                     + 31'(cin[k].frac_part * pow10(3'(MINUTE_FRAC_DIGITS) - cin[k].frac_cnt));
        end
    end

    // Stage 3 combinational: divide by 60 via reciprocal, apply sign
    always_comb
    begin
        for (int k = 0; k < 2; k++) begin
            q_c[k]   = 28'((61'(s2_num_reg[k]) * 61'(RECIP60)) >> RSH);
            mag_c[k] = 35'(s3_deg_reg[k]) * 35'd10000000 + 35'(s3_q_reg[k]);
            val_c[k] = s3_neg_reg[k] ? (35'd0 - mag_c[k]) : mag_c[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_status_reg <= in_data.status;
            s1_neg_reg    <= {cin[1].neg, cin[0].neg};
            s2_status_reg <= s1_status_reg;
            s2_neg_reg    <= s1_neg_reg;
            s3_status_reg <= s2_status_reg;
            s3_neg_reg    <= s2_neg_reg;
            for (int k = 0; k < 2; k++) begin
                s1_deg_reg[k] <= deg_c[k];
                s1_min_reg[k] <= min_c[k];
                s2_deg_reg[k] <= s1_deg_reg[k];
                s2_num_reg[k] <= 30'(s1_min_reg[k] * 31'(NUM_MUL));
                s3_deg_reg[k] <= s2_deg_reg[k];
                s3_q_reg[k]   <= q_c[k];
            end
        end
    end

    // Valid chain, held state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_NOT_RMC;
            held_fix_reg   <= 1'b0;
            held_lat_reg   <= '0;
            held_lon_reg   <= '0;
        end else if (adv) begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s3_valid_reg) begin
                out_status_reg <= s3_status_reg;
                if (s3_status_reg == ST_VALID) begin
                    held_fix_reg <= 1'b1;
                    held_lat_reg <= val_c[0];
                    held_lon_reg <= val_c[1];
                end else if (s3_status_reg == ST_NO_FIX || s3_status_reg == ST_EMPTY_POS) begin
                    held_fix_reg <= 1'b0;
                end
            end
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_status = out_status_reg;
    assign res_fix    = held_fix_reg;
    assign res_lat    = held_lat_reg;
    assign res_lon    = held_lon_reg;

endmodule

// File: src/nmea_rmc_position_parser_top.sv
// Usage notes for the NMEA RMC position parser.
// Input channel: rx_valid/rx_ready with one serial byte rx_byte per item.
// Output channel: out_valid/out_ready with status, fix_valid,
// latitude_e7 and longitude_e7 (signed 1e-7 degrees).
// CR bytes are skipped; a LF that ends a non-empty line yields one result,
// everything else yields none.
// Throughput: one byte per cycle while the queue is not full. The front
// scanner updates its line state on each accepted byte; the line is queued
// and the back end converts it through a four-register pipe (split degrees
// and minutes, scale minutes, reciprocal divide by 60, result register).
// The result follows the LF item through the queue and that pipe.
// When a result waits and out_ready is low the back pipe holds; the queue
// absorbs lines and rx_ready drops only when the queue is full (rx_ready
// is the inverse of the queue-full flag, whatever the byte).
// Reset clears the line state and the held fix/position to zero.
// Files: nrp_pkg, nrp_front, nrp_queue, nrp_back.
module nmea_rmc_position_parser_top #(
    parameter int MINUTE_FRAC_DIGITS = nrp_pkg::MINUTE_FRAC_DIGITS_DEF,
    parameter int MAX_FIELDS         = nrp_pkg::MAX_FIELDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic               fix_valid,
    output logic signed [34:0] latitude_e7,
    output logic signed [34:0] longitude_e7
);
    import nrp_pkg::*;

    logic  q_full, line_valid, q_valid, q_take;
    line_t line_data, q_data;

    assign rx_ready = !q_full;

    nrp_front #(
        .MINUTE_FRAC_DIGITS(MINUTE_FRAC_DIGITS),
        .MAX_FIELDS(MAX_FIELDS)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .byte_valid(rx_valid && rx_ready), .byte_data(rx_byte),
        .line_valid(line_valid), .line_data(line_data)
    );

    nrp_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_en(line_valid), .wr_data(line_data), .full(q_full),
        .rd_valid(q_valid), .rd_en(q_take), .rd_data(q_data)
    );

    nrp_back #(
        .MINUTE_FRAC_DIGITS(MINUTE_FRAC_DIGITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_take(q_take), .in_data(q_data),
        .res_valid(out_valid), .res_ready(out_ready),
        .res_status(status), .res_fix(fix_valid),
        .res_lat(latitude_e7), .res_lon(longitude_e7)
    );

endmodule

// File: src/nrp_checker.sv
// Port-level checker for the NMEA RMC position parser, bound to the top.
// Depends on nrp_pkg.
module nrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic        fix_valid,
    input logic [34:0] latitude_e7
);
    import nrp_pkg::*;

    // status stays within its codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_EMPTY_POS))
        else $error("bad status");

    // fix flag agrees with status for fix-deciding codes
    a_fix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_VALID |-> fix_valid)
        else $error("valid fix without flag");

    a_nofix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NO_FIX || status == ST_EMPTY_POS) |-> !fix_valid)
        else $error("fix flag set on no-fix line");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(latitude_e7))
        else $error("result changed while stalled");

endmodule

bind nmea_rmc_position_parser_top nrp_checker u_nrp_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .fix_valid(fix_valid), .latitude_e7(latitude_e7)
);

// File: dv/rmc_line_checker.sv
// Checker for the NMEA RMC position parser: follows the byte and result
// channels, predicts each line's result and compares. Depends on nrp_pkg.
`timescale 1ns / 1ps
module rmc_line_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    input  logic               rx_ready,
    input  logic [7:0]         rx_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [2:0]         status,
    input  logic               fix_valid,
    input  logic signed [34:0] latitude_e7,
    input  logic signed [34:0] longitude_e7,
    output int                 fail_count,
    output int                 pending_lines
);
    import nrp_pkg::*;

    localparam int FRAC_DIGITS = MINUTE_FRAC_DIGITS_DEF;
    localparam int LAST_FIELD  = MAX_FIELDS_DEF - 1;

    typedef struct {
        logic [2:0]  st;
        logic        fix;
        logic [34:0] lat;
        logic [34:0] lon;
    } fix_report_t;

    typedef struct {
        int   ip;
        int   fp;
        int   cnt;
        bit   nonempty;
        bit   dot;
        bit   ended;
        bit   hemi_seen;
        logic [7:0] hemi;
    } coord_acc_t;

    fix_report_t report_q[$];

    // line scanner state
    bit          in_line;
    int          pfx_pos;
    bit [1:0]    pfx_ok;
    int          comma_cnt;
    int          stat_chars;
    bit          stat_is_a;
    coord_acc_t  lat_acc, lon_acc;
    bit          held_fix;
    logic [34:0] held_lat, held_lon;

    function automatic coord_acc_t coord_clear();
        coord_acc_t a;
        a.ip = 0; a.fp = 0; a.cnt = 0;
        a.nonempty = 0; a.dot = 0; a.ended = 0; a.hemi_seen = 0; a.hemi = 8'h00;
        return a;
    endfunction

    function automatic coord_acc_t coord_char(coord_acc_t a, logic [7:0] c);
        a.nonempty = 1;
        if (a.ended)
            return a;
        if (c >= "0" && c <= "9") begin
            if (!a.dot) begin
                a.ip = a.ip * 10 + (c - "0");
                if (a.ip > INT_PART_MAX)
                    a.ip = INT_PART_MAX;
            end else if (a.cnt < FRAC_DIGITS) begin
                a.fp = a.fp * 10 + (c - "0");
                a.cnt++;
            end
        end else if (c == CH_DOT && !a.dot) begin
            a.dot = 1;
        end else begin
            a.ended = 1;
        end
        return a;
    endfunction

    // ddmm.mmmmm to 1e-7 degrees, truncated
    function automatic logic [34:0] degrees_e7(coord_acc_t a);
        longint scale, mins, mag, p;
        scale = 1;
        for (int i = 0; i < FRAC_DIGITS; i++)
            scale *= 10;
        p = 1;
        for (int i = 0; i < FRAC_DIGITS - a.cnt; i++)
            p *= 10;
        mins = longint'(a.ip % 100) * scale + longint'(a.fp) * p;
        mag  = longint'(a.ip / 100) * 10000000 + (mins * 10000000) / (60 * scale);
        if (a.hemi == CH_S || a.hemi == CH_W)
            mag = -mag;
        return mag[34:0];
    endfunction

    task automatic line_reset();
        in_line = 0; pfx_pos = 0; pfx_ok = 2'b11; comma_cnt = 0;
        stat_chars = 0; stat_is_a = 0;
        lat_acc = coord_clear();
        lon_acc = coord_clear();
    endtask

    task automatic take_byte(logic [7:0] c);
        fix_report_t r;
        if (c == CH_CR)
            return;
        if (c != CH_LF) begin
            in_line = 1;
            if (pfx_pos < 6) begin
                if (c != pfx_char(pfx_pos[2:0], 1'b0)) pfx_ok[0] = 0;
                if (c != pfx_char(pfx_pos[2:0], 1'b1)) pfx_ok[1] = 0;
                pfx_pos++;
            end
            if (c == CH_COMMA) begin
                if (comma_cnt < LAST_FIELD)
                    comma_cnt++;
                return;
            end
            case (comma_cnt)
                2: begin
                    if (stat_chars == 0)
                        stat_is_a = (c == CH_A);
                    if (stat_chars < 2)
                        stat_chars++;
                end
                3: lat_acc = coord_char(lat_acc, c);
                4: if (!lat_acc.hemi_seen) begin
                    lat_acc.hemi = c; lat_acc.hemi_seen = 1;
                end
                5: lon_acc = coord_char(lon_acc, c);
                6: if (!lon_acc.hemi_seen) begin
                    lon_acc.hemi = c; lon_acc.hemi_seen = 1;
                end
                default: ;
            endcase
            return;
        end
        if (!in_line)
            return;
        if (pfx_pos < 6 || pfx_ok == 2'b00) begin
            r.st = ST_NOT_RMC;
        end else if (comma_cnt < 6) begin
            r.st = ST_FEW;
        end else if (!(stat_chars == 1 && stat_is_a)) begin
            r.st = ST_NO_FIX;
            held_fix = 0;
        end else if (!lat_acc.nonempty || !lat_acc.hemi_seen ||
                     !lon_acc.nonempty || !lon_acc.hemi_seen) begin
            r.st = ST_EMPTY_POS;
            held_fix = 0;
        end else begin
            r.st = ST_VALID;
            held_fix = 1;
            held_lat = degrees_e7(lat_acc);
            held_lon = degrees_e7(lon_acc);
        end
        r.fix = held_fix;
        r.lat = held_lat;
        r.lon = held_lon;
        report_q.push_back(r);
        line_reset();
    endtask

    // predictor state is cleared while reset is held
    always @(posedge clk)
    begin
        fix_report_t e;
        if (!rst_n) begin
            fail_count = 0;
            held_fix = 0;
            held_lat = '0;
            held_lon = '0;
            line_reset();
            report_q.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (report_q.size() == 0) begin
                    $display("%0t: result with no line pending: st=%0d fix=%0d lat=%0d lon=%0d",
                             $time, status, fix_valid, latitude_e7, longitude_e7);
                    fail_count++;
                end else begin
                    e = report_q.pop_front();
                    if (status !== e.st) begin
                        $display("%0t: status exp %0d got %0d", $time, e.st, status);
                        fail_count++;
                    end
                    if (fix_valid !== e.fix) begin
                        $display("%0t: fix_valid exp %0d got %0d", $time, e.fix, fix_valid);
                        fail_count++;
                    end
                    if (latitude_e7 !== e.lat) begin
                        $display("%0t: latitude exp %0d got %0d", $time,
                                 $signed(e.lat), latitude_e7);
                        fail_count++;
                    end
                    if (longitude_e7 !== e.lon) begin
                        $display("%0t: longitude exp %0d got %0d", $time,
                                 $signed(e.lon), longitude_e7);
                        fail_count++;
                    end
                end
            end
            if (rx_valid && rx_ready)
                take_byte(rx_byte);
        end
        pending_lines = report_q.size();
    end
endmodule

// File: dv/nmea_rmc_position_parser_top_tb.sv
// Testbench top for the NMEA RMC position parser: clock, reset, byte
// stimulus and verdict. Depends on nrp_pkg, the block and rmc_line_checker.
`timescale 1ns / 1ps
module nmea_rmc_position_parser_top_tb;
    import nrp_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               rx_valid;
    logic               rx_ready;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic               fix_valid;
    logic signed [34:0] latitude_e7;
    logic signed [34:0] longitude_e7;
    int                 fail_count;
    int                 pending_lines;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  byte_count;

    nmea_rmc_position_parser_top dut (
        .clk(clk), .rst_n(rst_n),
        .rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .fix_valid(fix_valid),
        .latitude_e7(latitude_e7), .longitude_e7(longitude_e7)
    );

    rmc_line_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .fix_valid(fix_valid),
        .latitude_e7(latitude_e7), .longitude_e7(longitude_e7),
        .fail_count(fail_count), .pending_lines(pending_lines)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial
    begin
        out_ready = 0;
        @(negedge clk);
        forever begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 0;
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(byte c);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_valid <= 0;
            @(negedge clk);
        end
        rx_valid <= 1;
        rx_byte  <= c;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        @(negedge clk);
        byte_count++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic string rand_digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'("0" + $urandom_range(9)))};
        return s;
    endfunction

    // coordinate text: mostly well-formed, sometimes odd
    function automatic string rand_coord(int int_digits);
        string s;
        case ($urandom_range(9))
            0: s = "";
            1: s = rand_digits($urandom_range(1, 8));
            2: s = {rand_digits(int_digits), ".", rand_digits($urandom_range(0, 8)),
                    ".", rand_digits(2)};
            3: s = {"-", rand_digits(4)};
            4: s = {rand_digits(int_digits), "e", rand_digits(2)};
            default: s = {rand_digits(int_digits), ".", rand_digits($urandom_range(0, 7))};
        endcase
        return s;
    endfunction

    function automatic string rand_hemi(string a, string b);
        case ($urandom_range(7))
            0: return "";
            1: return string'(byte'($urandom_range(255)));
            2: return {a, "x"};
            default: return ($urandom_range(1)) ? a : b;
        endcase
    endfunction

    function automatic string rand_sentence();
        string s, stat;
        int nf;
        case ($urandom_range(5))
            0: stat = "V";
            1: stat = "";
            2: stat = "AA";
            default: stat = "A";
        endcase
        s = ($urandom_range(1)) ? "$GPRMC" : "$GNRMC";
        if ($urandom_range(15) == 0)
            s = "$GPGGA";
        if ($urandom_range(15) == 0)
            s = "$GPRM";
        s = {s, ",", rand_digits(6), ".00,", stat, ",",
             rand_coord(4), ",", rand_hemi("N", "S"), ",",
             rand_coord(5), ",", rand_hemi("E", "W")};
        nf = $urandom_range(0, 14);
        for (int i = 0; i < nf; i++)
            s = {s, ",", rand_digits($urandom_range(0, 3))};
        if ($urandom_range(9) == 0)
            s = s.substr(0, $urandom_range(0, s.len() - 1));
        return {s, ($urandom_range(1)) ? "\r\n" : "\n"};
    endfunction

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
            send_byte(byte'($urandom_range(255)));
        send_byte("\n");
    endtask

    task automatic random_phase(int n_bytes, int s_pct, int r_pct);
        int stop_at;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at = byte_count + n_bytes;
        while (byte_count < stop_at) begin
            if ($urandom_range(9) == 0)
                send_noise();
            else
                send_text(rand_sentence());
        end
    endtask

    initial
    begin
        rst_n = 0;
        rx_valid = 0;
        rx_byte = 0;
        hold_off = 0;
        byte_count = 0;
        send_idle_pct = 11;
        recv_idle_pct = 83;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed lines: special cases and field extremes
        send_text("\r\n\n");
        send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n");
        send_text("$GNRMC,0,A,9000.00000,S,18000.99999,W\n");
        send_text("$GNRMC,0,A,9999999.999999999,S,00000.0000001,W,,,,,,,,,,,,,,,,,,\n");
        send_text("$GPRMC,0,V,4807.038,N,01131.000,E\n");
        send_text("$GPRMC,0,A,,N,01131.000,E\n");
        send_text("$GPRMC,0,A,4807,,01131,E\n");
        send_text("$GPRMC,0,A,12.3.4,Nx,-5,Wy\n");
        send_text("$GPRMC,0,AB,1,N,1,E\n");
        send_text("$GPRMC,0,A,1,N\n");
        send_text("$GPGGA,0,A,1,N,1,E\n");
        send_text("$GP\n");
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte("\n");

        // sender keeps offering short lines while the receiver holds off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            repeat (40) send_noise();
        join

        random_phase(200, 11, 83);
        random_phase(200, 83, 11);
        random_phase(200, 0, 0);
        rx_valid <= 0;

        while (pending_lines != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// File: files.f
src/nrp_pkg.sv
src/nrp_front.sv
src/nrp_queue.sv
src/nrp_back.sv
src/nmea_rmc_position_parser_top.sv
src/nrp_checker.sv
dv/rmc_line_checker.sv
dv/nmea_rmc_position_parser_top_tb.sv
